FILE: rtl/gcb_pkg.sv
// Shared class codes and state type for the grapheme cluster boundary block.
`default_nettype none

package gcb_pkg;

  // Grapheme break classes as they arrive on the input stream.
  localparam logic [3:0] GC_OTHER   = 4'd0;
  localparam logic [3:0] GC_CR      = 4'd1;
  localparam logic [3:0] GC_LF      = 4'd2;
  localparam logic [3:0] GC_CONTROL = 4'd3;
  localparam logic [3:0] GC_L       = 4'd4;
  localparam logic [3:0] GC_V       = 4'd5;
  localparam logic [3:0] GC_T       = 4'd6;
  localparam logic [3:0] GC_LV      = 4'd7;
  localparam logic [3:0] GC_LVT     = 4'd8;
  localparam logic [3:0] GC_EXTEND  = 4'd9;
  localparam logic [3:0] GC_ZWJ     = 4'd10;
  localparam logic [3:0] GC_SPACING = 4'd11;
  localparam logic [3:0] GC_PREPEND = 4'd12;
  localparam logic [3:0] GC_EXTPICT = 4'd13;
  localparam logic [3:0] GC_RI      = 4'd14;
  // Running class only: pictographic, extends, then ZWJ.
  localparam logic [3:0] GC_EPZWJ   = 4'd15;

  // Indic conjunct classes.
  localparam logic [1:0] IC_NONE      = 2'd0;
  localparam logic [1:0] IC_CONSONANT = 2'd1;
  localparam logic [1:0] IC_LINKER    = 2'd2;
  localparam logic [1:0] IC_EXTEND    = 2'd3;

  // Stream widths.
  localparam int unsigned DATA_W = 8;

  // Summary of the cluster seen so far.
  typedef struct packed {
    logic [3:0] cluster_class;
    logic [1:0] conjunct_state;
  } gcb_state_t;

  localparam gcb_state_t STATE_RESET = '{cluster_class: GC_CONTROL, conjunct_state: IC_NONE};

endpackage

`default_nettype wire

FILE: rtl/gcb_rules.sv
// Boundary decision and next cluster state for one code point.
`default_nettype none

module gcb_rules
  import gcb_pkg::*;
(
  input  gcb_state_t       cur,
  input  logic       [3:0] break_class,
  input  logic       [1:0] conjunct_class,
  output logic             boundary,
  output gcb_state_t       nxt
);

  function automatic logic is_ctl(input logic [3:0] c);
    is_ctl = (c == GC_CR) || (c == GC_LF) || (c == GC_CONTROL);
  endfunction

  // Pair rules between the running class and the new class; first match wins.
  function automatic logic pair_breaks(input logic [3:0] a, input logic [3:0] b);
    logic r;
    r = 1'b1;
    priority if (a == GC_CR && b == GC_LF) begin
      r = 1'b0;
    end else if (is_ctl(a) || is_ctl(b)) begin
      r = 1'b1;
    end else if (a == GC_L &&
                 (b == GC_L || b == GC_V || b == GC_LV || b == GC_LVT)) begin
      r = 1'b0;
    end else if ((a == GC_LV || a == GC_V) && (b == GC_V || b == GC_T)) begin
      r = 1'b0;
    end else if ((a == GC_LVT || a == GC_T) && b == GC_T) begin
      r = 1'b0;
    end else if (b == GC_EXTEND || b == GC_ZWJ || b == GC_SPACING ||
                 a == GC_PREPEND) begin
      r = 1'b0;
    end else if (a == GC_EPZWJ && b == GC_EXTPICT) begin
      r = 1'b0;
    end else if (a == GC_RI && b == GC_RI) begin
      r = 1'b0;
    end else begin
      r = 1'b1;
    end
    pair_breaks = r;
  endfunction

  logic conj_join;

  // A linker followed by a consonant always joins the conjunct.
  assign conj_join = (cur.conjunct_state == IC_LINKER) && (conjunct_class == IC_CONSONANT);
  assign boundary  = pair_breaks(cur.cluster_class, break_class) && !conj_join;

  // Next state: restart on a boundary, otherwise extend the cluster.
  always_comb begin
    nxt = cur;
    if (boundary) begin
      nxt.cluster_class  = break_class;
      nxt.conjunct_state = (conjunct_class == IC_CONSONANT) ? IC_CONSONANT : IC_NONE;
    end else begin
      if (conjunct_class == IC_CONSONANT || cur.conjunct_state == IC_CONSONANT ||
          cur.conjunct_state == IC_EXTEND) begin
        nxt.conjunct_state = conjunct_class;
      end else if (cur.conjunct_state == IC_LINKER) begin
        nxt.conjunct_state = (conjunct_class == IC_EXTEND) ? IC_LINKER : conjunct_class;
      end

      if (cur.cluster_class == GC_RI && break_class == GC_RI) begin
        nxt.cluster_class = GC_OTHER;
      end else if (cur.cluster_class == GC_EXTPICT) begin
        if (break_class == GC_ZWJ) begin
          nxt.cluster_class = GC_EPZWJ;
        end else if (break_class != GC_EXTEND) begin
          nxt.cluster_class = break_class;
        end
      end else begin
        nxt.cluster_class = break_class;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/grapheme_cluster_boundary.sv
// Top level of the grapheme cluster boundary detector.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[3:0] break_class, tdata[5:4] conjunct_class
//   m_axis    out        tdata[0] boundary
//
// One code point per cycle sustained while the result is not stalled; each beat
// passes through the input register and then sits in the result register.
// The rate is set by the cluster state register, updated on every advancing beat.
// Reset restores the control class and an empty conjunct state, and empties
// both registers. A stalled result holds; the input register takes one more
// beat and then holds off the input until the result drains.
`default_nettype none

module grapheme_cluster_boundary
  import gcb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [3:0] break_class, [5:4] conjunct_class, [7:6] zero
  input  logic [DATA_W-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] boundary, [7:1] zero
  output logic [DATA_W-1:0] m_axis_tdata
);

  logic       in_valid;
  logic [3:0] in_break;
  logic [1:0] in_conj;
  logic       out_valid;
  logic       out_boundary;
  logic       advance;
  logic       boundary;
  gcb_state_t state;
  gcb_state_t state_next;

  // The held code point moves on when the result register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  gcb_rules u_rules (
    .cur            (state),
    .break_class    (in_break),
    .conjunct_class (in_conj),
    .boundary       (boundary),
    .nxt            (state_next)
  );

  // Control: valid flags and the cluster state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_break <= s_axis_tdata[3:0];
      in_conj  <= s_axis_tdata[5:4];
    end
    if (advance) begin
      out_boundary <= boundary;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(DATA_W-1){1'b0}}, out_boundary};

endmodule

`default_nettype wire

FILE: rtl/gcb_checker.sv
// Port-level checks for the grapheme cluster boundary detector, with its bind.
`default_nettype none

module gcb_checker
  import gcb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat present after reset");

  // With the result register empty the input side must take a beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register empty");

  // A stalled result beat holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // Padding bits above the boundary flag stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[DATA_W-1:1] == '0)
    else $error("result padding not zero");

endmodule

bind grapheme_cluster_boundary gcb_checker u_gcb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
